FILE: src/text_console_cell_engine_top_macros.svh
// Assertion macros for the text console cell engine RTL.
// Each macro expands to one labeled concurrent assertion on a clock and reset.
`ifndef TEXT_CONSOLE_CELL_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CELL_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCCE_ASSERT_IMPL(label, aclk, arst, ante, cons, msg) \
  label: assert property (@(posedge aclk) disable iff (arst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCCE_ASSERT_NEXT(label, aclk, arst, ante, cons, msg) \
  label: assert property (@(posedge aclk) disable iff (arst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tcce_pkg.sv
// Shared types and constants for the text console cell engine.
// No dependencies; used by every module of the block.
package tcce_pkg;

  // Default geometry and queue size
  localparam int DEF_ROW_WIDTH   = 64;
  localparam int DEF_ROW_COUNT   = 32;
  localparam int DEF_QUEUE_DEPTH = 4;

  // Field widths
  localparam int CHAR_W       = 8;
  localparam int COLOUR_W     = 4;
  localparam int ROW_OUT_W    = 5;
  localparam int COL_OUT_W    = 6;
  localparam int CURSOR_OUT_W = 12;

  // Draw limit per item
  localparam int MAX_DRAWS  = 64;
  localparam int DRAW_CNT_W = $clog2(MAX_DRAWS);

  // Key bytes
  localparam logic [CHAR_W-1:0] KEY_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] KEY_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] PRINT_LO      = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HI      = 8'd126;

  // Tab stops every four cells
  localparam int         TAB_BITS = 2;
  localparam logic [2:0] TAB_STEP = 3'd4;

  // Command codes handed from front to back
  localparam logic [2:0] OP_NOP       = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_NEWLINE   = 3'd2;
  localparam logic [2:0] OP_TAB       = 3'd3;
  localparam logic [2:0] OP_PRINT     = 3'd4;
  localparam logic [2:0] OP_BACKSPACE = 3'd5;

  typedef struct packed {
    logic [2:0]          op;
    logic [CHAR_W-1:0]   ch;
    logic [COLOUR_W-1:0] fore;
    logic [COLOUR_W-1:0] back;
  } cmd_t;

endpackage

FILE: src/tcce_front.sv
// Front end: accepts input items and classifies them into commands.
// Depends on tcce_pkg; feeds tcce_queue.
module tcce_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [tcce_pkg::CHAR_W-1:0]   key_code,
  input  logic [tcce_pkg::COLOUR_W-1:0] fore_colour,
  input  logic [tcce_pkg::COLOUR_W-1:0] back_colour,
  input  logic                          clearing,
  input  logic                          q_full,
  output logic                          q_push,
  output tcce_pkg::cmd_t                q_cmd
);

  logic [2:0] op;

  // Decode the key into a command code
  always_comb begin
    if (kind) begin
      op = tcce_pkg::OP_CLEAR;
    end else if (key_code == tcce_pkg::KEY_NEWLINE) begin
      op = tcce_pkg::OP_NEWLINE;
    end else if (key_code == tcce_pkg::KEY_TAB) begin
      op = tcce_pkg::OP_TAB;
    end else if (key_code == tcce_pkg::KEY_BACKSPACE) begin
      op = tcce_pkg::OP_BACKSPACE;
    end else if (key_code inside {[tcce_pkg::PRINT_LO:tcce_pkg::PRINT_HI]}) begin
      op = tcce_pkg::OP_PRINT;
    end else begin
      op = tcce_pkg::OP_NOP;
    end
  end

  // Hold off while the queue is full or the store is being swept
  assign in_stall = q_full | clearing;

  // Items that decode to no command are dropped here
  assign q_push     = in_valid & ~in_stall & (op != tcce_pkg::OP_NOP);
  assign q_cmd.op   = op;
  assign q_cmd.ch   = key_code;
  assign q_cmd.fore = fore_colour;
  assign q_cmd.back = back_colour;

endmodule

FILE: src/tcce_queue.sv
// Short command queue between the front end and the back end.
// Depends on tcce_pkg for the command type.
module tcce_queue #(
  parameter int DEPTH = tcce_pkg::DEF_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcce_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output tcce_pkg::cmd_t head,
  output logic           empty
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  tcce_pkg::cmd_t   slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: src/tcce_back.sv
// Back end: owns the cell store and cursor, runs each command and emits draws.
// Depends on tcce_pkg and the assertion macro header; fed by tcce_queue.
`include "text_console_cell_engine_top_macros.svh"

module tcce_back #(
  parameter int ROW_WIDTH = tcce_pkg::DEF_ROW_WIDTH,
  parameter int ROW_COUNT = tcce_pkg::DEF_ROW_COUNT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  tcce_pkg::cmd_t                    q_head,
  output logic                              q_pop,
  output logic                              clearing,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tcce_pkg::CHAR_W-1:0]       cell_char,
  output logic [tcce_pkg::ROW_OUT_W-1:0]    cell_row,
  output logic [tcce_pkg::COL_OUT_W-1:0]    cell_column,
  output logic [tcce_pkg::COLOUR_W-1:0]     draw_fore,
  output logic [tcce_pkg::COLOUR_W-1:0]     draw_back,
  output logic [tcce_pkg::CURSOR_OUT_W-1:0] cursor_index,
  output logic                              last_draw
);

  localparam int STORE_SIZE = ROW_WIDTH * ROW_COUNT;
  localparam int IW   = $clog2(STORE_SIZE + 1);
  localparam int AW   = $clog2(STORE_SIZE);
  localparam int CW   = $clog2(ROW_WIDTH);
  localparam int ROWW = $clog2(ROW_COUNT + 1);
  localparam int NW   = tcce_pkg::DRAW_CNT_W;
  localparam int CHW  = tcce_pkg::CHAR_W;
  localparam int CLW  = tcce_pkg::COLOUR_W;

  // Sequencer states
  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_BS_PREV = 3'd2;
  localparam logic [2:0] S_BS_SCAN = 3'd3;
  localparam logic [2:0] S_WALK    = 3'd4;
  localparam logic [2:0] S_EMIT    = 3'd5;

  logic [2:0]      state, state_next;
  logic [AW-1:0]   clr_addr, clr_addr_next;
  logic [IW-1:0]   cursor, cursor_next;
  logic [ROWW-1:0] cur_row, cur_row_next;
  logic [CW-1:0]   cur_col, cur_col_next;

  // Walk / scan position and draw bookkeeping
  logic [IW-1:0]   w, w_next;
  logic [ROWW-1:0] w_row, w_row_next;
  logic [CW-1:0]   w_col, w_col_next;
  logic            dir_up, dir_up_next;
  logic [NW-1:0]   n, n_next;
  logic            plast, plast_next;
  logic [CLW-1:0]  fg, fg_next;
  logic [CLW-1:0]  bg, bg_next;

  // Store ports
  logic [CHW-1:0]  mem [STORE_SIZE];
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [CHW-1:0]  wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [CHW-1:0]  rd_data;

  // Step helpers
  logic            at_end;
  logic            ci_wrap, cd_wrap, wi_wrap, wd_wrap;
  logic [IW-1:0]   ci, cd, wi, wd, ws, ws2;
  logic [ROWW-1:0] ci_row, cd_row, wi_row, wd_row, ws_row;
  logic [CW-1:0]   ci_col, cd_col, wi_col, wd_col, ws_col;
  logic [2:0]      tab_d;
  logic [IW:0]     tab_sum;
  logic [CW:0]     tab_col_sum;
  logic            tab_wrap;
  logic            w_at_end;
  logic            scan_empty;

  // Walk setup
  logic            go_walk;
  logic [IW-1:0]   tgt;
  logic [ROWW-1:0] tgt_row;
  logic [CW-1:0]   tgt_col;

  logic            out_free;
  logic            load_out;
  logic [IW-1:0]   cur_lin;

  assign clearing = (state == S_CLEAR);
  assign at_end   = (cursor == IW'(STORE_SIZE));
  assign w_at_end = (w == IW'(STORE_SIZE));
  assign out_free = ~out_valid | ~out_stall;

  // Cursor one step up and down, with row and column kept in step
  assign ci_wrap = (cur_col == CW'(ROW_WIDTH - 1));
  assign ci      = cursor + IW'(1);
  assign ci_row  = ci_wrap ? cur_row + ROWW'(1) : cur_row;
  assign ci_col  = ci_wrap ? '0 : cur_col + CW'(1);
  assign cd_wrap = (cur_col == '0);
  assign cd      = cursor - IW'(1);
  assign cd_row  = cd_wrap ? cur_row - ROWW'(1) : cur_row;
  assign cd_col  = cd_wrap ? CW'(ROW_WIDTH - 1) : cur_col - CW'(1);

  // Walk position one step up and down
  assign wi_wrap = (w_col == CW'(ROW_WIDTH - 1));
  assign wi      = w + IW'(1);
  assign wi_row  = wi_wrap ? w_row + ROWW'(1) : w_row;
  assign wi_col  = wi_wrap ? '0 : w_col + CW'(1);
  assign wd_wrap = (w_col == '0);
  assign wd      = w - IW'(1);
  assign wd_row  = wd_wrap ? w_row - ROWW'(1) : w_row;
  assign wd_col  = wd_wrap ? CW'(ROW_WIDTH - 1) : w_col - CW'(1);
  assign ws      = dir_up ? wi : wd;
  assign ws_row  = dir_up ? wi_row : wd_row;
  assign ws_col  = dir_up ? wi_col : wd_col;
  assign ws2     = dir_up ? w + IW'(2) : w - IW'(2);

  // Next tab stop from the cursor
  assign tab_d       = tcce_pkg::TAB_STEP - {1'b0, cursor[tcce_pkg::TAB_BITS-1:0]};
  assign tab_sum     = {1'b0, cursor} + (IW+1)'(tab_d);
  assign tab_col_sum = {1'b0, cur_col} + (CW+1)'(tab_d);
  assign tab_wrap    = (tab_col_sum >= (CW+1)'(ROW_WIDTH));

  // Backward scan stops on a nonempty cell or at cell zero
  assign scan_empty = w_at_end | (rd_data == '0);

  // Sequencer
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    cursor_next   = cursor;
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    w_next        = w;
    w_row_next    = w_row;
    w_col_next    = w_col;
    dir_up_next   = dir_up;
    n_next        = n;
    plast_next    = plast;
    fg_next       = fg;
    bg_next       = bg;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    q_pop         = 1'b0;
    load_out      = 1'b0;
    go_walk       = 1'b0;
    tgt           = cursor;
    tgt_row       = cur_row;
    tgt_col       = cur_col;

    case (state)
      // Zero the store one cell per cycle
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        if (clr_addr == AW'(STORE_SIZE - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      // Take the next command
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          fg_next = q_head.fore;
          bg_next = q_head.back;
          case (q_head.op)
            tcce_pkg::OP_CLEAR: begin
              cursor_next   = '0;
              cur_row_next  = '0;
              cur_col_next  = '0;
              clr_addr_next = '0;
              state_next    = S_CLEAR;
            end
            tcce_pkg::OP_NEWLINE: begin
              if (!at_end) begin
                wr_en   = 1'b1;
                wr_addr = AW'(cursor);
                wr_data = tcce_pkg::KEY_NEWLINE;
                tgt     = cursor + IW'(ROW_WIDTH) - IW'(cur_col);
                tgt_row = cur_row + ROWW'(1);
                tgt_col = '0;
                go_walk = 1'b1;
              end
            end
            tcce_pkg::OP_TAB: begin
              if (!at_end) begin
                wr_en   = 1'b1;
                wr_addr = AW'(cursor);
                wr_data = tcce_pkg::KEY_TAB;
                go_walk = 1'b1;
                if (tab_sum > (IW+1)'(STORE_SIZE)) begin
                  tgt     = IW'(STORE_SIZE);
                  tgt_row = ROWW'(ROW_COUNT);
                  tgt_col = '0;
                end else if (tab_wrap) begin
                  tgt     = IW'(tab_sum);
                  tgt_row = cur_row + ROWW'(1);
                  tgt_col = CW'(tab_col_sum - (CW+1)'(ROW_WIDTH));
                end else begin
                  tgt     = IW'(tab_sum);
                  tgt_col = CW'(tab_col_sum);
                end
              end
            end
            tcce_pkg::OP_PRINT: begin
              if (!at_end) begin
                wr_en   = 1'b1;
                wr_addr = AW'(cursor);
                wr_data = q_head.ch;
                tgt     = ci;
                tgt_row = ci_row;
                tgt_col = ci_col;
                go_walk = 1'b1;
              end
            end
            tcce_pkg::OP_BACKSPACE: begin
              if (cursor != '0) begin
                rd_en      = 1'b1;
                rd_addr    = AW'(cd);
                state_next = S_BS_PREV;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Previous cell printable: erase it and step back once; otherwise start the backward scan
      S_BS_PREV: begin
        if (rd_data inside {[tcce_pkg::PRINT_LO:tcce_pkg::PRINT_HI]}) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cd);
          tgt     = cd;
          tgt_row = cd_row;
          tgt_col = cd_col;
          go_walk = 1'b1;
        end else begin
          w_next     = cursor;
          w_row_next = cur_row;
          w_col_next = cur_col;
          rd_en      = ~at_end;
          rd_addr    = AW'(cursor);
          state_next = S_BS_SCAN;
        end
      end

      // Walk back over empty cells, one read per cycle
      S_BS_SCAN: begin
        if (w != '0 && scan_empty) begin
          w_next     = wd;
          w_row_next = wd_row;
          w_col_next = wd_col;
          rd_en      = 1'b1;
          rd_addr    = AW'(wd);
        end else begin
          go_walk = 1'b1;
          if (!w_at_end && (rd_data == tcce_pkg::KEY_NEWLINE ||
                            rd_data == tcce_pkg::KEY_TAB)) begin
            wr_en   = 1'b1;
            wr_addr = AW'(w);
            tgt     = w;
            tgt_row = w_row;
            tgt_col = w_col;
          end else begin
            tgt     = wi;
            tgt_row = wi_row;
            tgt_col = wi_col;
          end
        end
      end

      // First draw of the walk; the position past the store is skipped
      S_WALK: begin
        if (w == cursor) begin
          state_next = S_IDLE;
        end else if (w_at_end) begin
          w_next     = ws;
          w_row_next = ws_row;
          w_col_next = ws_col;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(w);
          plast_next = (n == NW'(tcce_pkg::MAX_DRAWS - 1)) || (ws == cursor);
          state_next = S_EMIT;
        end
      end

      // One draw per cycle while the output register frees up
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (plast) begin
            state_next = S_IDLE;
          end else begin
            w_next     = ws;
            w_row_next = ws_row;
            w_col_next = ws_col;
            n_next     = n + NW'(1);
            rd_en      = 1'b1;
            rd_addr    = AW'(ws);
            plast_next = (n == NW'(tcce_pkg::MAX_DRAWS - 2)) || (ws2 == cursor);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Commit the new cursor and start the walk from the old one
    if (go_walk) begin
      cursor_next  = tgt;
      cur_row_next = tgt_row;
      cur_col_next = tgt_col;
      w_next       = cursor;
      w_row_next   = cur_row;
      w_col_next   = cur_col;
      dir_up_next  = (tgt > cursor);
      n_next       = '0;
      state_next   = (tgt == cursor) ? S_IDLE : S_WALK;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cursor   <= '0;
      cur_row  <= '0;
      cur_col  <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      cursor   <= cursor_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    w      <= w_next;
    w_row  <= w_row_next;
    w_col  <= w_col_next;
    dir_up <= dir_up_next;
    n      <= n_next;
    plast  <= plast_next;
    fg     <= fg_next;
    bg     <= bg_next;
  end

  // Cell store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cell_char    <= rd_data;
      cell_row     <= tcce_pkg::ROW_OUT_W'(w_row);
      cell_column  <= tcce_pkg::COL_OUT_W'(w_col);
      draw_fore    <= fg;
      draw_back    <= bg;
      cursor_index <= tcce_pkg::CURSOR_OUT_W'(cursor);
      last_draw    <= plast;
    end
  end

  // Linear cursor index rebuilt from row and column, for the checks
  assign cur_lin = IW'(IW'(cur_row) * IW'(ROW_WIDTH) + IW'(cur_col));

  // Checks
  `TCCE_ASSERT_IMPL(a_cursor_range, clk, rst, 1'b1, cursor <= IW'(STORE_SIZE), "cursor past store")
  `TCCE_ASSERT_IMPL(a_cursor_rowcol, clk, rst, 1'b1, cursor == cur_lin, "cursor out of step")
  `TCCE_ASSERT_IMPL(a_emit_in_store, clk, rst, state == S_EMIT, w < IW'(STORE_SIZE), "draw past store")
  `TCCE_ASSERT_IMPL(a_out_from_emit, clk, rst, $rose(out_valid), $past(state) == S_EMIT, "stray draw")
  `TCCE_ASSERT_NEXT(a_clear_home, clk, rst, state == S_CLEAR, cursor == '0, "cursor not home")

endmodule

FILE: src/text_console_cell_engine_top.sv
// Text console cell engine: key items in, cell draw commands out.
// Input channel (in_valid/in_stall): kind, key_code and two colour indexes.
//   Newline, tab, printable bytes and backspace edit a cleared cell store and
//   move a cursor; kind = 1 clears the store and homes the cursor.
// Output channel (out_valid/out_stall): one item per cell the cursor crossed,
//   up to 64 per key, with the cell byte, row, column, colours, the new cursor
//   and last_draw on the final one. Keys that move nothing give no items.
// Accepted keys go through a command queue (4 entries by default) to a sequencer
//   that owns the store (one write and one registered read port) and issues one
//   draw per cycle while the output register is free. Each key is popped in the
//   idle state, then walks (first read) and emits through the output register;
//   backspace first reads the previous cell and, if it is not printable, scans
//   back over empty cells (up to the store size, 2048 by default).
// After reset and after each clear item the store is swept to zero, one cell
//   per cycle; in_stall is high meanwhile.
//   in_stall is also high while the command queue is full.
// When out_stall is high the finished draw waits in the output register and
//   the sequencer holds; the front keeps taking keys until the queue fills.
// Depends on tcce_pkg, tcce_front, tcce_queue and tcce_back.
module text_console_cell_engine_top #(
  parameter int ROW_WIDTH   = tcce_pkg::DEF_ROW_WIDTH,
  parameter int ROW_COUNT   = tcce_pkg::DEF_ROW_COUNT,
  parameter int QUEUE_DEPTH = tcce_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [tcce_pkg::CHAR_W-1:0]       key_code,
  input  logic [tcce_pkg::COLOUR_W-1:0]     fore_colour,
  input  logic [tcce_pkg::COLOUR_W-1:0]     back_colour,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tcce_pkg::CHAR_W-1:0]       cell_char,
  output logic [tcce_pkg::ROW_OUT_W-1:0]    cell_row,
  output logic [tcce_pkg::COL_OUT_W-1:0]    cell_column,
  output logic [tcce_pkg::COLOUR_W-1:0]     draw_fore,
  output logic [tcce_pkg::COLOUR_W-1:0]     draw_back,
  output logic [tcce_pkg::CURSOR_OUT_W-1:0] cursor_index,
  output logic                              last_draw
);

  logic           q_push;
  tcce_pkg::cmd_t q_cmd;
  logic           q_full;
  logic           q_pop;
  tcce_pkg::cmd_t q_head;
  logic           q_empty;
  logic           clearing;

  tcce_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .key_code    (key_code),
    .fore_colour (fore_colour),
    .back_colour (back_colour),
    .clearing    (clearing),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  tcce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  tcce_back #(
    .ROW_WIDTH (ROW_WIDTH),
    .ROW_COUNT (ROW_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cell_char    (cell_char),
    .cell_row     (cell_row),
    .cell_column  (cell_column),
    .draw_fore    (draw_fore),
    .draw_back    (draw_back),
    .cursor_index (cursor_index),
    .last_draw    (last_draw)
  );

endmodule
